// ----- sv/bsse_pkg.sv -----
package bsse_pkg;

    // Field widths of the stream items.
    localparam int KIND_W     = 2;
    localparam int KIDX_W     = 5;
    localparam int KVAL_W     = 17;
    localparam int ROWCOL_W   = 4;
    localparam int COORD_W    = 32;
    localparam int PARAM_W    = 17;
    localparam int S_DATA_W   = 160;
    localparam int M_DATA_W   = 96;

    // Fixed-point datapath widths.
    localparam int BASIS_W    = 18;
    localparam int PROD_W     = 36;
    localparam int QSUM_W     = 37;
    localparam int WEIGHT_W   = 20;
    localparam int GPROD_W    = 52;
    localparam int ACC_W      = 60;
    localparam int FRAC_W     = 16;

    localparam logic signed [BASIS_W-1:0] BASIS_ONE = 18'sd65536;
    localparam logic signed [BASIS_W-1:0] BASIS_MAX = 18'sd131071;
    localparam logic signed [BASIS_W-1:0] BASIS_MIN = -18'sd131072;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;
    localparam logic [1:0] REG_U_DEGREE = 2'd0;
    localparam logic [1:0] REG_V_DEGREE = 2'd1;
    localparam logic [1:0] REG_U_COUNT  = 2'd2;
    localparam logic [1:0] REG_V_COUNT  = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_U     = 2'd0,
        KIND_LOAD_V     = 2'd1,
        KIND_LOAD_POINT = 2'd2,
        KIND_EVAL       = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic [KIDX_W-1:0]           knot_index;
        logic [KVAL_W-1:0]           knot_value;
        logic [ROWCOL_W-1:0]         point_row;
        logic [ROWCOL_W-1:0]         point_col;
        logic signed [COORD_W-1:0]   point_x;
        logic signed [COORD_W-1:0]   point_y;
        logic signed [COORD_W-1:0]   point_z;
        logic [PARAM_W-1:0]          u_param;
        logic [PARAM_W-1:0]          v_param;
    } req_t;

    typedef struct packed {
        logic [1:0] u_degree;
        logic [1:0] v_degree;
        logic [4:0] u_point_count;
        logic [4:0] v_point_count;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_BINIT,
        ST_ROT,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_K4,
        ST_DIV1,
        ST_DIV2,
        ST_BSUM,
        ST_BOUT,
        ST_ACC_RD,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_DONE
    } bsse_state_t;

endpackage

// ----- sv/bsse_front.sv -----
module bsse_front import bsse_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]   s_tuser,
    output logic                q_valid,
    output req_t                q_req,
    input  logic                q_pop
);

    localparam int DEPTH = 2;

    req_t       fifo_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    req_t       in_req;
    logic       push;
    logic       pop;

    // Unpack the stream word into a typed request.
    always_comb begin
        in_req.kind       = kind_t'(s_tuser);
        in_req.knot_index = s_tdata[4:0];
        in_req.knot_value = s_tdata[21:5];
        in_req.point_row  = s_tdata[25:22];
        in_req.point_col  = s_tdata[29:26];
        in_req.point_x    = s_tdata[61:30];
        in_req.point_y    = s_tdata[93:62];
        in_req.point_z    = s_tdata[125:94];
        in_req.u_param    = s_tdata[142:126];
        in_req.v_param    = s_tdata[159:143];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = fifo_reg[rd_ptr_reg];

    // Request storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_req;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- sv/bsse_div.sv -----
module bsse_div import bsse_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [PROD_W-1:0]  dividend,
    input  logic signed [BASIS_W-1:0] divisor,
    output logic                      done,
    output logic signed [PROD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PROD_W-1:0]  quo_reg;
    logic [BASIS_W:0]   rem_reg;
    logic [BASIS_W-1:0] dmag_reg;
    logic               neg_reg;
    logic [BASIS_W:0]   rem_shift;
    logic [BASIS_W:0]   rem_sub;
    logic               fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_shift = {rem_reg[BASIS_W-1:0], quo_reg[PROD_W-1]};
    assign fits      = (rem_shift >= {1'b0, dmag_reg});
    assign rem_sub   = rem_shift - {1'b0, dmag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PROD_W);
                quo_reg  <= dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
                rem_reg  <= '0;
                dmag_reg <= divisor[BASIS_W-1] ? BASIS_W'(-divisor) : BASIS_W'(divisor);
                neg_reg  <= dividend[PROD_W-1] ^ divisor[BASIS_W-1];
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[PROD_W-2:0], fits};
                rem_reg <= fits ? rem_sub : rem_shift;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient truncates toward zero: sign is applied to the magnitude.
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ----- sv/bsse_back.sv -----
module bsse_back import bsse_pkg::*; #(
    parameter int MAX_DEGREE   = 3,
    parameter int MAX_U_POINTS = 16,
    parameter int MAX_V_POINTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                q_valid,
    input  req_t                q_req,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int D     = MAX_DEGREE;
    localparam int L     = D + 2;
    localparam int HW    = $clog2(L);
    localparam int DW    = $clog2(D + 1);
    localparam int MAXP  = (MAX_U_POINTS > MAX_V_POINTS) ? MAX_U_POINTS : MAX_V_POINTS;
    localparam int U_KD  = MAX_U_POINTS + D + 1;
    localparam int V_KD  = MAX_V_POINTS + D + 1;
    localparam int KD    = MAXP + D + 1;
    localparam int KAW   = $clog2(KD);
    localparam int IW    = $clog2(KD + 1);
    localparam int CW    = $clog2(MAXP + 1);
    localparam int GD    = MAX_U_POINTS * MAX_V_POINTS;
    localparam int GAW   = $clog2(GD);
    localparam logic signed [ACC_W-1:0]  ACC_RND = ACC_W'(65535);
    localparam logic signed [PROD_W-1:0] W_RND   = PROD_W'(65535);
    localparam logic signed [ACC_W-1:0]  OUT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0]  OUT_MIN = ACC_W'(-64'sd2147483648);

    bsse_state_t state_reg, state_next;

    // Stored tables.
    logic [KVAL_W-1:0]         u_knot_mem [KD];
    logic [KVAL_W-1:0]         v_knot_mem [KD];
    logic signed [COORD_W-1:0] grid_x_mem [GD];
    logic signed [COORD_W-1:0] grid_y_mem [GD];
    logic signed [COORD_W-1:0] grid_z_mem [GD];
    logic [KVAL_W-1:0]         urd_reg, vrd_reg;
    logic signed [COORD_W-1:0] gx_rd_reg, gy_rd_reg, gz_rd_reg;

    // Evaluation context.
    logic                      dir_reg;
    logic [PARAM_W-1:0]        tu_reg, tv_reg;
    logic [CW-1:0]             ucnt_reg, vcnt_reg, ucnt_eff, vcnt_eff;
    logic [DW-1:0]             pu_reg, pv_reg, pu_eff, pv_eff;
    logic [KAW-1:0]            su_reg, sv_reg, span_found;
    logic [IW-1:0]             i_reg;
    logic [DW-1:0]             j_reg;
    logic [HW-1:0]             h_reg, h_inc;
    logic signed [BASIS_W-1:0] ring_reg [L];
    logic [KVAL_W-1:0]         uk_reg, ukj_reg, uk1_reg, ukj1_reg;
    logic signed [PROD_W-1:0]  q1_reg, q2_reg;
    logic                      div_started_reg;
    logic signed [BASIS_W-1:0] bu_reg [D+1];
    logic signed [BASIS_W-1:0] bv_reg [D+1];
    logic [DW-1:0]             mu_reg, mv_reg;
    logic signed [WEIGHT_W-1:0] w_reg;
    logic signed [GPROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [ACC_W-1:0]   accx_reg, accy_reg, accz_reg;
    logic                      m_valid_reg;
    logic [M_DATA_W-1:0]       m_data_reg;

    // Per-direction selections.
    logic [CW-1:0]             cnt_cur;
    logic [DW-1:0]             p_cur;
    logic [PARAM_W-1:0]        t_cur;
    logic [KAW-1:0]            span_cur;
    logic [KVAL_W-1:0]         krd;
    logic [KAW-1:0]            kaddr;
    logic [GAW-1:0]            gaddr;
    logic                      nk_hit;
    logic                      t_below;
    logic                      rot_hit;

    // Recurrence term operands.
    logic signed [BASIS_W-1:0] n_cur, num_cur, den_cur;
    logic signed [PROD_W-1:0]  term_prod;
    logic                      term_zero;
    logic                      div_start;
    logic                      div_done;
    logic signed [PROD_W-1:0]  div_quo;
    logic                      div_exit;
    logic signed [QSUM_W-1:0]  qsum;
    logic signed [BASIS_W-1:0] bsum_sat;
    logic signed [PROD_W-1:0]  wprod, wadj;
    logic signed [WEIGHT_W-1:0] w_next;
    logic                      acc_last;

    assign cnt_cur  = dir_reg ? vcnt_reg : ucnt_reg;
    assign p_cur    = dir_reg ? pv_reg : pu_reg;
    assign t_cur    = dir_reg ? tv_reg : tu_reg;
    assign span_cur = dir_reg ? sv_reg : su_reg;
    assign krd      = dir_reg ? vrd_reg : urd_reg;
    assign h_inc    = (h_reg == HW'(L - 1)) ? '0 : h_reg + 1'b1;
    assign nk_hit   = (int'(i_reg) == int'(cnt_cur) + int'(p_cur) + 1);
    assign t_below  = (t_cur < krd);
    assign rot_hit  = (int'(h_reg) == int'(p_cur) - int'(j_reg));
    assign acc_last = (mu_reg == pu_reg) && (mv_reg == pv_reg);

    // Effective counts and degrees after clamping.
    always_comb begin
        int c;
        int d;
        c = int'(cfg.u_point_count);
        if (c < 2) c = 2;
        else if (c > MAX_U_POINTS) c = MAX_U_POINTS;
        d = int'(cfg.u_degree);
        if (d < 1) d = 1;
        else if (d > D) d = D;
        if (d > c - 1) d = c - 1;
        ucnt_eff = CW'(c);
        pu_eff   = DW'(d);
    end

    always_comb begin
        int c;
        int d;
        c = int'(cfg.v_point_count);
        if (c < 2) c = 2;
        else if (c > MAX_V_POINTS) c = MAX_V_POINTS;
        d = int'(cfg.v_degree);
        if (d < 1) d = 1;
        else if (d > D) d = D;
        if (d > c - 1) d = c - 1;
        vcnt_eff = CW'(c);
        pv_eff   = DW'(d);
    end

    // Span is one below the first knot above t, clamped to the valid spans.
    always_comb begin
        int s;
        s = int'(i_reg) - 1;
        if (s < int'(p_cur)) s = int'(p_cur);
        if (s > int'(cnt_cur) - 1) s = int'(cnt_cur) - 1;
        span_found = KAW'(s);
    end

    // Knot read address for the search and for the four knots of one term pair.
    always_comb begin
        int k;
        k = int'(span_cur) - int'(p_cur) + int'(h_reg);
        case (state_reg)
            ST_SRCH_RD: kaddr = KAW'(i_reg);
            ST_K0:      kaddr = KAW'(k);
            ST_K1:      kaddr = KAW'(k + int'(j_reg));
            ST_K2:      kaddr = KAW'(k + 1);
            ST_K3:      kaddr = KAW'(k + int'(j_reg) + 1);
            default:    kaddr = '0;
        endcase
    end

    // Control point address for the current basis pair.
    always_comb begin
        int r;
        int c;
        r = int'(su_reg) - int'(pu_reg) + int'(mu_reg);
        c = int'(sv_reg) - int'(pv_reg) + int'(mv_reg);
        gaddr = GAW'(r * MAX_V_POINTS + c);
    end

    // Operands of the left or right term of the recurrence.
    always_comb begin
        if (state_reg == ST_DIV2) begin
            n_cur   = ring_reg[1];
            num_cur = BASIS_W'($signed({1'b0, ukj1_reg}) - $signed({1'b0, t_cur}));
            den_cur = BASIS_W'($signed({1'b0, ukj1_reg}) - $signed({1'b0, uk1_reg}));
        end else begin
            n_cur   = ring_reg[0];
            num_cur = BASIS_W'($signed({1'b0, t_cur}) - $signed({1'b0, uk_reg}));
            den_cur = BASIS_W'($signed({1'b0, ukj_reg}) - $signed({1'b0, uk_reg}));
        end
        term_prod = n_cur * num_cur;
        term_zero = (n_cur == '0) || (den_cur == '0);
    end

    assign div_start = ((state_reg == ST_DIV1) || (state_reg == ST_DIV2))
                       && !div_started_reg && !term_zero;
    assign div_exit  = (!div_started_reg && term_zero) || (div_started_reg && div_done);

    bsse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (term_prod),
        .divisor  (den_cur),
        .done     (div_done),
        .quotient (div_quo)
    );

    // New basis value: sum of both terms, saturated.
    always_comb begin
        qsum = QSUM_W'(q1_reg) + QSUM_W'(q2_reg);
        if (qsum > QSUM_W'(BASIS_MAX)) bsum_sat = BASIS_MAX;
        else if (qsum < QSUM_W'(BASIS_MIN)) bsum_sat = BASIS_MIN;
        else bsum_sat = BASIS_W'(qsum);
    end

    // Weight of one control point, truncated toward zero.
    always_comb begin
        wprod  = bu_reg[mu_reg] * bv_reg[mv_reg];
        wadj   = wprod + (wprod[PROD_W-1] ? W_RND : '0);
        w_next = WEIGHT_W'(wadj >>> FRAC_W);
    end

    // Knot tables.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && q_valid && (q_req.kind == KIND_LOAD_U)
                && (int'(q_req.knot_index) < U_KD)) begin
            u_knot_mem[KAW'(q_req.knot_index)] <= q_req.knot_value;
        end
        if ((state_reg == ST_IDLE) && q_valid && (q_req.kind == KIND_LOAD_V)
                && (int'(q_req.knot_index) < V_KD)) begin
            v_knot_mem[KAW'(q_req.knot_index)] <= q_req.knot_value;
        end
        urd_reg <= u_knot_mem[kaddr];
        vrd_reg <= v_knot_mem[kaddr];
    end

    // Control point grid.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && q_valid && (q_req.kind == KIND_LOAD_POINT)
                && (int'(q_req.point_row) < MAX_U_POINTS)
                && (int'(q_req.point_col) < MAX_V_POINTS)) begin
            grid_x_mem[GAW'(int'(q_req.point_row) * MAX_V_POINTS + int'(q_req.point_col))]
                <= q_req.point_x;
            grid_y_mem[GAW'(int'(q_req.point_row) * MAX_V_POINTS + int'(q_req.point_col))]
                <= q_req.point_y;
            grid_z_mem[GAW'(int'(q_req.point_row) * MAX_V_POINTS + int'(q_req.point_col))]
                <= q_req.point_z;
        end
        gx_rd_reg <= grid_x_mem[gaddr];
        gy_rd_reg <= grid_y_mem[gaddr];
        gz_rd_reg <= grid_z_mem[gaddr];
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && (q_req.kind == KIND_EVAL)) state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD:  state_next = nk_hit ? ST_BINIT : ST_SRCH_CMP;
            ST_SRCH_CMP: state_next = t_below ? ST_BINIT : ST_SRCH_RD;
            ST_BINIT:    state_next = ST_K0;
            ST_ROT:      state_next = rot_hit ? ST_K0 : ST_ROT;
            ST_K0:       state_next = ST_K1;
            ST_K1:       state_next = ST_K2;
            ST_K2:       state_next = ST_K3;
            ST_K3:       state_next = ST_K4;
            ST_K4:       state_next = ST_DIV1;
            ST_DIV1:     state_next = div_exit ? ST_DIV2 : ST_DIV1;
            ST_DIV2:     state_next = div_exit ? ST_BSUM : ST_DIV2;
            ST_BSUM: begin
                if (int'(h_reg) == int'(p_cur)) begin
                    state_next = (j_reg == p_cur) ? ST_BOUT : ST_ROT;
                end else begin
                    state_next = ST_K0;
                end
            end
            ST_BOUT: begin
                if (h_reg == '0) state_next = dir_reg ? ST_ACC_RD : ST_SRCH_RD;
            end
            ST_ACC_RD:   state_next = ST_ACC_MUL;
            ST_ACC_MUL:  state_next = ST_ACC_ADD;
            ST_ACC_ADD:  state_next = acc_last ? ST_DONE : ST_ACC_RD;
            ST_DONE:     state_next = m_valid_reg ? ST_DONE : ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // Sequencer datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                dir_reg  <= 1'b0;
                i_reg    <= '0;
                tu_reg   <= q_req.u_param;
                tv_reg   <= q_req.v_param;
                ucnt_reg <= ucnt_eff;
                vcnt_reg <= vcnt_eff;
                pu_reg   <= pu_eff;
                pv_reg   <= pv_eff;
            end
            ST_SRCH_RD: begin
                if (nk_hit) begin
                    if (dir_reg) sv_reg <= span_found;
                    else su_reg <= span_found;
                end
            end
            ST_SRCH_CMP: begin
                if (t_below) begin
                    if (dir_reg) sv_reg <= span_found;
                    else su_reg <= span_found;
                end else begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            ST_BINIT: begin
                for (int e = 0; e < L; e++) begin
                    ring_reg[e] <= (e == 1) ? BASIS_ONE : '0;
                end
                h_reg <= HW'(int'(p_cur) - 1);
                j_reg <= DW'(1);
            end
            ST_ROT: begin
                if (!rot_hit) begin
                    for (int e = 0; e < L - 1; e++) ring_reg[e] <= ring_reg[e+1];
                    ring_reg[L-1] <= ring_reg[0];
                    h_reg <= h_inc;
                end
            end
            ST_K1: uk_reg   <= krd;
            ST_K2: ukj_reg  <= krd;
            ST_K3: uk1_reg  <= krd;
            ST_K4: ukj1_reg <= krd;
            ST_DIV1: begin
                if (div_exit) q1_reg <= div_started_reg ? div_quo : '0;
            end
            ST_DIV2: begin
                if (div_exit) q2_reg <= div_started_reg ? div_quo : '0;
            end
            ST_BSUM: begin
                // Ring moves on by one; the new value of this span goes to the tail.
                for (int e = 0; e < L - 1; e++) ring_reg[e] <= ring_reg[e+1];
                ring_reg[L-1] <= bsum_sat;
                h_reg <= h_inc;
                if ((int'(h_reg) == int'(p_cur)) && (j_reg != p_cur)) begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            ST_BOUT: begin
                if (h_reg == '0) begin
                    for (int e = 0; e <= D; e++) begin
                        if (dir_reg) bv_reg[e] <= ring_reg[e];
                        else bu_reg[e] <= ring_reg[e];
                    end
                    dir_reg  <= 1'b1;
                    i_reg    <= '0;
                    mu_reg   <= '0;
                    mv_reg   <= '0;
                    accx_reg <= '0;
                    accy_reg <= '0;
                    accz_reg <= '0;
                end else begin
                    for (int e = 0; e < L - 1; e++) ring_reg[e] <= ring_reg[e+1];
                    ring_reg[L-1] <= ring_reg[0];
                    h_reg <= h_inc;
                end
            end
            ST_ACC_RD: w_reg <= w_next;
            ST_ACC_MUL: begin
                px_reg <= gx_rd_reg * w_reg;
                py_reg <= gy_rd_reg * w_reg;
                pz_reg <= gz_rd_reg * w_reg;
            end
            ST_ACC_ADD: begin
                accx_reg <= accx_reg + ACC_W'(px_reg);
                accy_reg <= accy_reg + ACC_W'(py_reg);
                accz_reg <= accz_reg + ACC_W'(pz_reg);
                if (mv_reg == pv_reg) begin
                    mv_reg <= '0;
                    mu_reg <= mu_reg + 1'b1;
                end else begin
                    mv_reg <= mv_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Divider handshake flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_started_reg <= 1'b0;
        end else if (div_start) begin
            div_started_reg <= 1'b1;
        end else if (div_started_reg && div_done) begin
            div_started_reg <= 1'b0;
        end
    end

    // Scale an accumulator back to Q16.16 and saturate.
    function automatic logic [COORD_W-1:0] scale_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] adj;
        logic signed [ACC_W-1:0] q;
        adj = a + (a[ACC_W-1] ? ACC_RND : '0);
        q   = adj >>> FRAC_W;
        if (q > OUT_MAX) return COORD_W'(OUT_MAX);
        else if (q < OUT_MIN) return COORD_W'(OUT_MIN);
        else return COORD_W'(q);
    endfunction

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && !m_valid_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && !m_valid_reg) begin
            m_data_reg <= {scale_sat(accz_reg), scale_sat(accy_reg), scale_sat(accx_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- sv/bspline_surface_point_eval.sv -----
// Tensor-product B-spline surface point evaluator. Requests on the s_ stream
// either load a u knot, a v knot or a control point (no result), or ask
// for the surface point at (u,v), which returns one x/y/z result on the m_
// stream. An evaluation scans the knots, reading and comparing each in turn,
// to find the span in each direction, then builds the basis by the Cox-de
// Boor recurrence: each of the p(p+3)/2 basis updates per direction uses the
// bit-serial divider once for each of its two terms that is not zero.
// The weighted sum reads, multiplies and accumulates each control point in
// turn. A two-entry request queue lets loads and new requests be taken while
// a result waits on the output register. Degrees and point counts are set
// through the APB port; the user must set them while the block is idle, which
// the block itself does not enforce. Out-of-range values are clamped.
module bspline_surface_point_eval import bsse_pkg::*; #(
    parameter int MAX_DEGREE   = 3,
    parameter int MAX_U_POINTS = 16,
    parameter int MAX_V_POINTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // knot_index, knot_value, point_row, point_col, point_x, point_y,
    // point_z, u_param, v_param
    input  logic [S_DATA_W-1:0]   s_tdata,
    // kind
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // surf_x, surf_y, surf_z
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg_reg;
    logic q_valid;
    req_t q_req;
    logic q_pop;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.u_degree      <= 2'd3;
            cfg_reg.v_degree      <= 2'd3;
            cfg_reg.u_point_count <= 5'd4;
            cfg_reg.v_point_count <= 5'd4;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_U_DEGREE: cfg_reg.u_degree      <= pwdata[1:0];
                REG_V_DEGREE: cfg_reg.v_degree      <= pwdata[1:0];
                REG_U_COUNT:  cfg_reg.u_point_count <= pwdata[4:0];
                REG_V_COUNT:  cfg_reg.v_point_count <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_U_DEGREE: prdata = APB_DATA_W'(cfg_reg.u_degree);
            REG_V_DEGREE: prdata = APB_DATA_W'(cfg_reg.v_degree);
            REG_U_COUNT:  prdata = APB_DATA_W'(cfg_reg.u_point_count);
            REG_V_COUNT:  prdata = APB_DATA_W'(cfg_reg.v_point_count);
            default:      prdata = '0;
        endcase
    end

    bsse_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop)
    );

    bsse_back #(
        .MAX_DEGREE   (MAX_DEGREE),
        .MAX_U_POINTS (MAX_U_POINTS),
        .MAX_V_POINTS (MAX_V_POINTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- sv/bsse_checker.sv -----
module bsse_checker import bsse_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [KIND_W-1:0]     s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  psel,
    input logic [PADDR_W-1:0]    paddr,
    input logic [APB_DATA_W-1:0] prdata
);

    logic [3:0] pend_reg;
    logic       eval_in;
    logic       res_out;

    assign eval_in = s_tvalid && s_tready && (s_tuser == KIND_EVAL);
    assign res_out = m_tvalid && m_tready;

    // Evaluation requests taken but not yet answered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 4'd0;
        end else begin
            pend_reg <= pend_reg + 4'(eval_in) - 4'(res_out);
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every result answers an evaluation request.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 4'd0)
        else $error("result without a pending evaluation");

    // Reset empties the output.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The u degree register reads back in two bits.
    a_degree_width: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && (paddr[3:2] == REG_U_DEGREE) |-> prdata[31:2] == '0)
        else $error("degree register reads wide");

endmodule

bind bspline_surface_point_eval bsse_checker u_bsse_checker (.*);
